// ----- sv/dsp_pkg.sv -----
// Package for the shortest path block: item words, function codes and field widths.
// No dependencies; dijkstra_shortest_path imports it.
package dsp_pkg;

  localparam int NODE_FIELD_BITS = 6;
  localparam int WEIGHT_FIELD_BITS = 8;
  localparam int DIST_FIELD_BITS = 16;
  localparam int CFG_BITS = 7;
  localparam int MAX_RESULTS = 64;
  localparam int K_BITS = 6;
  localparam logic [CFG_BITS-1:0] NODES_RESET = 7'd64;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                         func;
    logic [NODE_FIELD_BITS-1:0]   from_node;
    logic [NODE_FIELD_BITS-1:0]   to_node;
    logic [WEIGHT_FIELD_BITS-1:0] weight;
    logic [NODE_FIELD_BITS-1:0]   start_node;
    logic [NODE_FIELD_BITS-1:0]   end_node;
  } dsp_in_t;

  typedef struct packed {
    logic [NODE_FIELD_BITS-1:0] path_node;
    logic [DIST_FIELD_BITS-1:0] distance;
    logic                       reachable;
    logic                       last;
  } dsp_out_t;

endpackage

// ----- sv/dijkstra_shortest_path.sv -----
// Shortest path search over a stored adjacency matrix, one node compared per cycle.
// Edge write: no result. Query over n nodes: a load pass, then up to n-2
// rounds of a scan pass and a relax pass on one memory read port,
// then one path word per visit of ST_TR_ADDR and ST_TR_DATA. A bad node answers next cycle.
// Reset (rst_n, synchronous) zeroes the edge store one entry a cycle, busy over NODES*NODES
// entries. Result words are one-cycle strobes on out_valid; the receiver cannot stall them.
module dijkstra_shortest_path #(
  parameter int NODES       = 64,
  parameter int WEIGHT_BITS = 8,
  parameter int DIST_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  dsp_pkg::dsp_in_t               in_word,
  output logic                           out_valid,
  output dsp_pkg::dsp_out_t              out_word,
  input  logic                           cfg_we,
  input  logic [dsp_pkg::CFG_BITS-1:0]   cfg_wdata
);
  import dsp_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);
  localparam int EW = $clog2(NODES * NODES);
  localparam int SW = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam logic [DIST_BITS-1:0] DIST_INF = '1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_INIT, ST_SCAN, ST_RELAX, ST_TR_ADDR, ST_TR_DATA
  } state_t;

  typedef struct packed {
    logic                 vis;
    logic [NW-1:0]        pred;
    logic [DIST_BITS-1:0] cost;
  } node_rec_t;

  function automatic logic [EW-1:0] edge_addr(input logic [NW-1:0] row,
                                              input logic [NW-1:0] col);
    edge_addr = EW'(row) * EW'(NODES) + EW'(col);
  endfunction

  // Memories
  logic [WEIGHT_BITS-1:0] edge_mem [NODES*NODES];
  node_rec_t              node_mem [NODES];

  logic                   ew_we;
  logic [EW-1:0]          ew_waddr, ew_raddr;
  logic [WEIGHT_BITS-1:0] ew_wdata, ew_q;
  logic                   st_we;
  logic [NW-1:0]          st_waddr, st_raddr;
  node_rec_t              st_wdata, st_q;

  // Control and data registers
  state_t                 state_r, state_nxt;
  logic [EW-1:0]          clr_r, clr_nxt;
  logic [CFG_BITS-1:0]    cfg_nodes_r, cfg_nodes_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [NW-1:0]          s_r, s_nxt;
  logic [NW-1:0]          e_r, e_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   pipe_vld_r, pipe_vld_nxt;
  logic [NW-1:0]          pipe_idx_r, pipe_idx_nxt;
  logic [CW-1:0]          rounds_r, rounds_nxt;
  logic [DIST_BITS-1:0]   best_r, best_nxt;
  logic [NW-1:0]          pick_r, pick_nxt;
  logic                   found_r, found_nxt;
  logic [NW-1:0]          cur_r, cur_nxt;
  logic [K_BITS-1:0]      k_r, k_nxt;
  logic [DIST_BITS-1:0]   dist_out_r, dist_out_nxt;
  logic                   out_valid_r, out_valid_nxt;
  dsp_out_t               out_word_r, out_word_nxt;

  // Combinational helpers
  logic                   issue_en;
  logic                   pass_done;
  logic [CW-1:0]          n_eff;
  logic [SW-1:0]          relax_sum;
  logic [DIST_BITS-1:0]   init_cost;
  logic [DIST_BITS-1:0]   d_sel;
  logic                   last_flag;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign issue_en  = (idx_r < n_r);
  assign pass_done = !issue_en && !pipe_vld_r;
  assign relax_sum = SW'(best_r) + SW'(ew_q);
  assign init_cost = ((ew_q == '0) || (SW'(ew_q) >= SW'(DIST_INF))) ? DIST_INF
                                                                     : DIST_BITS'(ew_q);
  assign d_sel     = (k_r == '0) ? st_q.cost : dist_out_r;
  assign last_flag = (cur_r == s_r) || (k_r == K_BITS'(MAX_RESULTS - 1));

  always_comb begin
    if (cfg_nodes_r < CFG_BITS'(2)) begin
      n_eff = CW'(2);
    end else if (32'(cfg_nodes_r) > NODES) begin
      n_eff = CW'(NODES);
    end else begin
      n_eff = CW'(cfg_nodes_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ew_we) begin
      edge_mem[ew_waddr] <= ew_wdata;
    end
    ew_q <= edge_mem[ew_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      node_mem[st_waddr] <= st_wdata;
    end
    st_q <= node_mem[st_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cfg_nodes_nxt = cfg_we ? cfg_wdata : cfg_nodes_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    idx_nxt       = idx_r;
    pipe_vld_nxt  = 1'b0;
    pipe_idx_nxt  = pipe_idx_r;
    rounds_nxt    = rounds_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    dist_out_nxt  = dist_out_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    ew_we    = 1'b0;
    ew_waddr = clr_r;
    ew_wdata = '0;
    ew_raddr = edge_addr((state_r == ST_INIT) ? s_r : pick_r, idx_r[NW-1:0]);
    st_we    = 1'b0;
    st_waddr = pipe_idx_r;
    st_wdata = st_q;
    st_raddr = idx_r[NW-1:0];

    // The three matrix passes share one issue pipeline: address now, data next cycle.
    if (state_r == ST_INIT || state_r == ST_SCAN || state_r == ST_RELAX) begin
      if (issue_en) begin
        idx_nxt = idx_r + CW'(1);
      end
      pipe_vld_nxt = issue_en;
      pipe_idx_nxt = idx_r[NW-1:0];
    end

    case (state_r)
      ST_CLEAR: begin
        ew_we   = 1'b1;
        clr_nxt = clr_r + EW'(1);
        if (clr_r == EW'(NODES * NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (in_word.func == FUNC_WRITE) begin
            if (32'(in_word.from_node) < NODES && 32'(in_word.to_node) < NODES) begin
              ew_we    = 1'b1;
              ew_waddr = edge_addr(NW'(in_word.from_node), NW'(in_word.to_node));
              ew_wdata = WEIGHT_BITS'(in_word.weight);
            end
          end else if (CW'(in_word.start_node) >= n_eff ||
                       32'(in_word.start_node) >= 32'(n_eff) ||
                       32'(in_word.end_node) >= 32'(n_eff)) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{path_node: in_word.end_node,
                              distance:  DIST_FIELD_BITS'(DIST_INF),
                              reachable: 1'b0,
                              last:      1'b1};
          end else begin
            n_nxt     = n_eff;
            s_nxt     = NW'(in_word.start_node);
            e_nxt     = NW'(in_word.end_node);
            idx_nxt   = '0;
            state_nxt = ST_INIT;
          end
        end
      end

      ST_INIT: begin
        if (pipe_vld_r) begin
          st_we         = 1'b1;
          st_wdata.vis  = (pipe_idx_r == s_r);
          st_wdata.pred = s_r;
          st_wdata.cost = (pipe_idx_r == s_r) ? '0 : init_cost;
        end
        if (pass_done) begin
          rounds_nxt = CW'(1);
          idx_nxt    = '0;
          best_nxt   = DIST_INF;
          found_nxt  = 1'b0;
          if (n_r > CW'(2)) begin
            state_nxt = ST_SCAN;
          end else begin
            cur_nxt   = e_r;
            k_nxt     = '0;
            state_nxt = ST_TR_ADDR;
          end
        end
      end

      ST_SCAN: begin
        // Strict compare keeps the lowest index on ties.
        if (pipe_vld_r && !st_q.vis && st_q.cost < best_r) begin
          best_nxt  = st_q.cost;
          pick_nxt  = pipe_idx_r;
          found_nxt = 1'b1;
        end
        if (pass_done) begin
          idx_nxt = '0;
          if (found_r) begin
            state_nxt = ST_RELAX;
          end else begin
            cur_nxt   = e_r;
            k_nxt     = '0;
            state_nxt = ST_TR_ADDR;
          end
        end
      end

      ST_RELAX: begin
        // The picked node is marked visited as the pass walks past it.
        if (pipe_vld_r) begin
          if (pipe_idx_r == pick_r) begin
            st_we        = 1'b1;
            st_wdata.vis = 1'b1;
          end else if (!st_q.vis && ew_q != '0 && relax_sum < SW'(st_q.cost)) begin
            st_we    = 1'b1;
            st_wdata = '{vis: 1'b0, pred: pick_r, cost: DIST_BITS'(relax_sum)};
          end
        end
        if (pass_done) begin
          rounds_nxt = rounds_r + CW'(1);
          idx_nxt    = '0;
          best_nxt   = DIST_INF;
          found_nxt  = 1'b0;
          if ((CW+1)'(rounds_r) + (CW+1)'(2) < (CW+1)'(n_r)) begin
            state_nxt = ST_SCAN;
          end else begin
            cur_nxt   = e_r;
            k_nxt     = '0;
            state_nxt = ST_TR_ADDR;
          end
        end
      end

      ST_TR_ADDR: begin
        st_raddr  = cur_r;
        state_nxt = ST_TR_DATA;
      end

      ST_TR_DATA: begin
        out_valid_nxt = 1'b1;
        if (k_r == '0) begin
          dist_out_nxt = st_q.cost;
        end
        if (d_sel == DIST_INF) begin
          out_word_nxt = '{path_node: NODE_FIELD_BITS'(e_r),
                           distance:  DIST_FIELD_BITS'(DIST_INF),
                           reachable: 1'b0,
                           last:      1'b1};
          state_nxt    = ST_IDLE;
        end else begin
          out_word_nxt = '{path_node: NODE_FIELD_BITS'(cur_r),
                           distance:  DIST_FIELD_BITS'(d_sel),
                           reachable: 1'b1,
                           last:      last_flag};
          if (last_flag) begin
            state_nxt = ST_IDLE;
          end else begin
            cur_nxt   = ((CW+1)'(st_q.pred) >= (CW+1)'(n_r)) ? s_r : st_q.pred;
            k_nxt     = k_r + K_BITS'(1);
            state_nxt = ST_TR_ADDR;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cfg_nodes_r <= NODES_RESET;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cfg_nodes_r <= cfg_nodes_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    idx_r      <= idx_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    rounds_r   <= rounds_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    found_r    <= found_nxt;
    cur_r      <= cur_nxt;
    k_r        <= k_nxt;
    dist_out_r <= dist_out_nxt;
    out_word_r <= out_word_nxt;
  end

  // The edge store is written only by the clearing sweep or by an edge write word.
  a_edge_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ew_we |-> (state_r == ST_CLEAR || state_r == ST_IDLE))
    else $error("edge store written during a query");

  // Pipelined passes never touch a node beyond the active count.
  a_pipe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_vld_r |-> (CW'(pipe_idx_r) < n_r))
    else $error("pass index beyond node count");

  // An unreachable answer is always a single, final word.
  a_unreach_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.reachable) |-> out_word_r.last)
    else $error("unreachable word without last");

  // A word that is not last is followed by the next predecessor lookup.
  a_chain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.last) |-> (state_r == ST_TR_ADDR))
    else $error("path chain stopped early");

  // No result appears while the edge store is being cleared.
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result during clearing sweep");

endmodule

// ----- sim/dijkstra_shortest_path_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dijkstra_shortest_path: predicts every path word from its own
// copy of the edge store and node count. Depends on dsp_pkg and the block under test.

module dijkstra_shortest_path_tb;
  import dsp_pkg::*;

  localparam int NODE_COUNT = 64;
  localparam int DIST_SAT = 65535;
  localparam int MAX_MISMATCH_PRINTS = 10;
  localparam int RANDOM_ITEMS = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  dsp_in_t              in_word;
  logic                 out_valid;
  dsp_out_t             out_word;
  logic                 cfg_we;
  logic [CFG_BITS-1:0]  cfg_wdata;

  // Shadow of the block's edge store and node count.
  logic [WEIGHT_FIELD_BITS-1:0] link_weight [0:NODE_COUNT*NODE_COUNT-1];
  logic [CFG_BITS-1:0]          node_limit;
  bit                           link_set [0:NODE_COUNT*NODE_COUNT-1];
  int                           placed_links[$];

  dsp_out_t expected_hops[$];
  dsp_out_t head_hop;
  int       mismatch_count;
  int       burst_left;
  int       sent_items;

  dijkstra_shortest_path dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int eff_nodes(logic [CFG_BITS-1:0] v);
    if (v < 2) return 2;
    if (v > NODE_COUNT) return NODE_COUNT;
    return int'(v);
  endfunction

  function automatic int unsigned link_cost(int a, int b);
    logic [WEIGHT_FIELD_BITS-1:0] w;
    w = link_weight[a * NODE_COUNT + b];
    return (w == 0) ? DIST_SAT : int'(w);
  endfunction

  function automatic dsp_out_t hop(int node, int unsigned hop_dist, bit reach, bit fin);
    dsp_out_t r;
    r.path_node = node[NODE_FIELD_BITS-1:0];
    r.distance  = hop_dist[DIST_FIELD_BITS-1:0];
    r.reachable = reach;
    r.last      = fin;
    return r;
  endfunction

  // Updates the edge store for a write, or runs the search and queues the path words.
  function automatic void predict_word(dsp_in_t w);
    int unsigned node_dist [NODE_COUNT];
    int          pred [NODE_COUNT];
    bit          seen [NODE_COUNT];
    int          n, s, e, i, pick, node, k, rounds;
    int unsigned best, c;
    bit          found, at_start, cut;
    if (w.func == FUNC_WRITE) begin
      link_weight[{w.from_node, w.to_node}] = w.weight;
      return;
    end
    n = eff_nodes(node_limit);
    s = int'(w.start_node);
    e = int'(w.end_node);
    if (s >= n || e >= n) begin
      expected_hops.push_back(hop(e, DIST_SAT, 1'b0, 1'b1));
      return;
    end
    for (i = 0; i < n; i++) begin
      node_dist[i] = link_cost(s, i);
      pred[i] = s;
      seen[i] = 1'b0;
    end
    node_dist[s] = 0;
    seen[s] = 1'b1;
    for (rounds = 1; rounds + 1 < n; rounds++) begin
      best = DIST_SAT;
      pick = 0;
      found = 1'b0;
      // Strict compare keeps the lowest index on a tie.
      for (i = 0; i < n; i++) begin
        if (!seen[i] && node_dist[i] < best) begin
          best = node_dist[i];
          pick = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      seen[pick] = 1'b1;
      for (i = 0; i < n; i++) begin
        if (!seen[i]) begin
          c = best + link_cost(pick, i);
          if (c >= DIST_SAT) c = DIST_SAT;
          if (c < node_dist[i]) begin
            node_dist[i] = c;
            pred[i] = pick;
          end
        end
      end
    end
    if (node_dist[e] >= DIST_SAT) begin
      expected_hops.push_back(hop(e, DIST_SAT, 1'b0, 1'b1));
      return;
    end
    k = 0;
    node = e;
    while (1) begin
      at_start = (node == s);
      cut = (k == MAX_RESULTS - 1);
      expected_hops.push_back(hop(node, node_dist[e], 1'b1, at_start || cut));
      k++;
      if (at_start || cut) break;
      node = pred[node];
      if (node >= n) node = s;
    end
  endfunction

  // Every result word is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_hops.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_MISMATCH_PRINTS)
          $display("%0t: unexpected word node=%0d dist=%0d reach=%0b last=%0b", $realtime,
                   out_word.path_node, out_word.distance, out_word.reachable, out_word.last);
      end else begin
        head_hop = expected_hops.pop_front();
        if (out_word.path_node !== head_hop.path_node || out_word.distance !== head_hop.distance ||
            out_word.reachable !== head_hop.reachable || out_word.last !== head_hop.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_MISMATCH_PRINTS)
            $display("%0t: expected node=%0d dist=%0d reach=%0b last=%0b, actual node=%0d dist=%0d reach=%0b last=%0b",
                     $realtime, head_hop.path_node, head_hop.distance, head_hop.reachable,
                     head_hop.last, out_word.path_node, out_word.distance, out_word.reachable,
                     out_word.last);
        end
      end
    end
  end

  task automatic send_word(dsp_in_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk) start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    predict_word(w);
    burst_left--;
    sent_items++;
  endtask

  task automatic link(int f, int t, int wgt);
    dsp_in_t w;
    int idx;
    w.func       = FUNC_WRITE;
    w.from_node  = NODE_FIELD_BITS'(f);
    w.to_node    = NODE_FIELD_BITS'(t);
    w.weight     = WEIGHT_FIELD_BITS'(wgt);
    w.start_node = NODE_FIELD_BITS'($urandom_range(0, 63));
    w.end_node   = NODE_FIELD_BITS'($urandom_range(0, 63));
    idx = f * NODE_COUNT + t;
    if (wgt != 0 && !link_set[idx]) begin
      link_set[idx] = 1'b1;
      placed_links.push_back(idx);
    end
    send_word(w);
  endtask

  task automatic query(int s, int e);
    dsp_in_t w;
    w.func       = FUNC_QUERY;
    w.from_node  = NODE_FIELD_BITS'($urandom_range(0, 63));
    w.to_node    = NODE_FIELD_BITS'($urandom_range(0, 63));
    w.weight     = WEIGHT_FIELD_BITS'($urandom_range(0, 255));
    w.start_node = NODE_FIELD_BITS'(s);
    w.end_node   = NODE_FIELD_BITS'(e);
    send_word(w);
  endtask

  task automatic clear_links();
    int idx;
    while (placed_links.size() != 0) begin
      idx = placed_links.pop_front();
      link_set[idx] = 1'b0;
      link(idx / NODE_COUNT, idx % NODE_COUNT, 0);
    end
  endtask

  // Waits until every predicted word has come and the block has gone idle.
  task automatic settle();
    @(negedge clk) start <= 1'b0;
    burst_left = 0;
    while (expected_hops.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_nodes(logic [CFG_BITS-1:0] v);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    node_limit = v;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    settle();
    query(0, 63);
    query(5, 5);
    query(63, 0);
  endtask

  task automatic test_corner_cases();
    set_nodes(2);
    link(0, 1, 255);
    link(63, 63, 255);
    link(63, 0, 1);
    query(0, 1);
    query(1, 0);
    query(0, 5);
    query(40, 1);
    set_nodes(0);
    query(0, 1);
    set_nodes(1);
    query(1, 1);
    // Two equal routes to node 3: the lower-numbered middle node wins.
    set_nodes(4);
    link(0, 1, 5);
    link(0, 2, 5);
    link(1, 3, 5);
    link(2, 3, 5);
    query(0, 3);
    link(0, 1, 0);
    query(0, 3);
    query(3, 0);
    set_nodes(127);
    query(63, 0);
  endtask

  // A single chain through all nodes in shuffled order gives the longest possible path.
  task automatic test_long_path();
    int order [NODE_COUNT];
    int i, j, tmp;
    set_nodes(64);
    clear_links();
    for (i = 0; i < NODE_COUNT; i++) order[i] = i;
    for (i = NODE_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i + 1 < NODE_COUNT; i++) link(order[i], order[i + 1], $urandom_range(1, 255));
    query(order[0], order[NODE_COUNT - 1]);
    query(order[NODE_COUNT - 1], order[0]);
  endtask

  task automatic test_random_graphs();
    logic [CFG_BITS-1:0] v;
    int first_item, n, i, writes, queries, f, t, wgt, s, e;
    first_item = sent_items;
    while (sent_items - first_item < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       v = CFG_BITS'($urandom_range(0, 1));
        1:       v = CFG_BITS'(64);
        2:       v = CFG_BITS'($urandom_range(65, 127));
        default: v = CFG_BITS'($urandom_range(2, 10));
      endcase
      set_nodes(v);
      n = eff_nodes(v);
      if ($urandom_range(0, 1) == 0) clear_links();
      writes = (n == NODE_COUNT) ? 24 : $urandom_range(n, 3 * n);
      queries = (n == NODE_COUNT) ? 2 : $urandom_range(3, 6);
      for (i = 0; i < writes; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          f = $urandom_range(0, 63);
          t = $urandom_range(0, 63);
        end else begin
          f = $urandom_range(0, n - 1);
          t = $urandom_range(0, n - 1);
        end
        case ($urandom_range(0, 7))
          0:       wgt = 0;
          1:       wgt = 255;
          2:       wgt = $urandom_range(1, 4);
          default: wgt = $urandom_range(1, 255);
        endcase
        link(f, t, wgt);
      end
      for (i = 0; i < queries; i++) begin
        case ($urandom_range(0, 7))
          0: begin
            s = $urandom_range(0, 63);
            e = $urandom_range(0, 63);
          end
          1: begin
            s = $urandom_range(0, n - 1);
            e = s;
          end
          default: begin
            s = $urandom_range(0, n - 1);
            e = $urandom_range(0, n - 1);
          end
        endcase
        query(s, e);
      end
    end
  endtask

  initial begin
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = NODES_RESET;
    rst_n = 1'b0;
    node_limit = NODES_RESET;
    mismatch_count = 0;
    burst_left = 0;
    sent_items = 0;
    for (int i = 0; i < NODE_COUNT * NODE_COUNT; i++) begin
      link_weight[i] = '0;
      link_set[i] = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_corner_cases();
    test_long_path();
    test_random_graphs();

    settle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_hops.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dsp_pkg.sv
sv/dijkstra_shortest_path.sv
sim/dijkstra_shortest_path_tb.sv
